/* design/pfp_pkg.sv */
// Package for the potential-field planner step unit.
// Shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps

package pfp_pkg;

  typedef struct packed {
    logic               start_valid;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
    logic signed [23:0] obst_x;
    logic signed [23:0] obst_y;
    logic        [22:0] obst_size;
  } in_item_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic               repulsion_active;
  } out_item_t;

  // configuration register indexes
  localparam logic [2:0] CFG_ATTRACT  = 3'd0;
  localparam logic [2:0] CFG_REPEL    = 3'd1;
  localparam logic [2:0] CFG_INFLUENCE = 3'd2;
  localparam logic [2:0] CFG_STEP     = 3'd3;
  localparam logic [2:0] CFG_ARRIVE   = 3'd4;

  localparam logic [15:0] ATTRACT_RST  = 16'd128;
  localparam logic [15:0] REPEL_RST    = 16'd2560;
  localparam logic [22:0] INFLUENCE_RST = 23'd2048;
  localparam logic [22:0] STEP_RST     = 23'd41;
  localparam logic [22:0] ARRIVE_RST   = 23'd410;

  localparam logic [63:0] FMAX = 64'd2147483647;
  localparam logic [63:0] GCAP = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {SH_0, SH_8, SH_24} sh_t;
  typedef enum logic [1:0] {CAP_NONE, CAP_F, CAP_G} cap_t;

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_NEXT, ST_FIN} state_t;

  typedef enum logic [4:0] {
    U_DX2, U_DY2, U_SQG, U_FAX, U_FAY, U_PX2, U_PY2, U_SQO,
    U_INVD, U_INVD0, U_G1, U_G2, U_G3, U_G4, U_RFX, U_RFY,
    U_FX2, U_FY2, U_SQF, U_SX, U_DVX, U_SY, U_DVY
  } uop_t;

  typedef struct packed {
    logic load;
    logic start;
    logic wr;
    logic emit;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic arrived;
    logic rep;
    logic fzero;
    logic done;
    logic out_full;
  } sts_t;

endpackage

/* design/potential_field_planner_step_unit.sv */
// Potential-field planner step unit. One request at a time on shared iterative units
// (multiply, square root and divide). A tick stops early when not started, when arrived
// or when the force is zero, and does extra work with repulsion. The next request is
// taken in the cycle after the result enters the output register; a finished result
// waits in the output register meanwhile.
// Synchronous active-low reset restores the register defaults and clears position.
`timescale 1ns / 1ps

module potential_field_planner_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);
  import pfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pfp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  pfp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_no_rep_without_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |-> !out_data.repulsion_active)
    else $error("repulsion flagged without a path point");

  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |->
      out_data.point_x == 24'sd0 && out_data.point_y == 24'sd0)
    else $error("nonzero point without a path point");

endmodule

/* design/pfp_mul.sv */
// Shift-add multiplier, 63 x 37 bits, one partial product per cycle.
// Result optionally shifted right by 8 or 24 and saturated; uses pfp_pkg.
`timescale 1ns / 1ps

module pfp_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [62:0]   a,
  input  logic [36:0]   b,
  input  pfp_pkg::sh_t  sh,
  input  pfp_pkg::cap_t cap,
  output logic          done,
  output logic [63:0]   res
);
  import pfp_pkg::*;

  localparam logic [5:0] LAST = 6'd36;

  logic         busy_r, done_r;
  logic [5:0]   cnt_r;
  logic [99:0]  acc_r, a_sh_r, acc_nxt, shifted;
  logic [36:0]  b_sh_r;
  sh_t          sh_r;
  cap_t         cap_r;

  assign acc_nxt = acc_r + (b_sh_r[0] ? a_sh_r : 100'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_sh_r <= 100'(a);
      b_sh_r <= b;
      sh_r   <= sh;
      cap_r  <= cap;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
    end
  end

  always_comb begin
    case (sh_r)
      SH_8:    shifted = acc_r >> 8;
      SH_24:   shifted = acc_r >> 24;
      default: shifted = acc_r;
    endcase
    case (cap_r)
      CAP_F:   res = (shifted > 100'(FMAX)) ? FMAX : shifted[63:0];
      CAP_G:   res = (shifted > 100'(GCAP)) ? GCAP : shifted[63:0];
      default: res = shifted[63:0];
    endcase
  end

  assign done = done_r;

endmodule

/* design/pfp_sqrt.sv */
// Digit-by-digit integer square root of a 64-bit value, one digit per cycle.
// Uses pfp_pkg.
`timescale 1ns / 1ps

module pfp_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] res
);
  import pfp_pkg::*;

  localparam logic [4:0] LAST = 5'd31;

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] n_r, r_r, b_r, trial;

  assign trial = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= x;
      r_r <= '0;
      b_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign res  = r_r[31:0];

endmodule

/* design/pfp_div.sv */
// Restoring divider, 55-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Uses pfp_pkg.
`timescale 1ns / 1ps

module pfp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [54:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [54:0] quo
);
  import pfp_pkg::*;

  localparam logic [5:0] LAST = 6'd54;

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [54:0] num_r, q_r;
  logic [31:0] den_r, rem_r;
  logic [32:0] rem_sh;
  logic        fit;

  assign rem_sh = {rem_r, num_r[54]};
  assign fit    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= fit ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      q_r   <= {q_r[53:0], fit};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* design/pfp_datapath.sv */
// Planner datapath: config registers, state, operand routing and the
// shared multiply, square root and divide units. Uses pfp_pkg.
`timescale 1ns / 1ps

module pfp_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pfp_pkg::cmd_t      cmd,
  output pfp_pkg::sts_t      sts,
  input  pfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);
  import pfp_pkg::*;

  logic [15:0] attract_r, repel_r;
  logic [22:0] influence_r, step_r, arrive_r;

  logic signed [23:0] pos_x_r, pos_y_r, gx_r, gy_r, ox_r, oy_r, pt_x_r, pt_y_r;
  logic [21:0]        radius_r;
  logic               started_r, arrived_r, rep_r, pv_r;
  logic [63:0]        t0_r, t1_r;
  logic signed [31:0] fx_r, fy_r;
  logic [22:0]        surf_r;
  logic [36:0]        invd_r;
  logic [62:0]        g_r;
  logic [31:0]        fabs_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic signed [24:0] dx, dy, px, py;
  logic [24:0]        adx, ady, apx, apy;
  logic [30:0]        afx, afy;

  logic        mul_go, sq_go, dv_go, mul_done, sq_done, dv_done;
  logic [62:0] mul_a;
  logic [36:0] mul_b;
  sh_t         mul_sh;
  cap_t        mul_cap;
  logic [63:0] mul_res;
  logic [31:0] sq_res;
  logic [54:0] dv_num, dv_q;
  logic [31:0] dv_den;

  logic signed [33:0] surf_raw, surf_cl;

  function automatic logic signed [31:0] sat_f(input logic signed [32:0] v);
    if (v > 33'sd2147483647)       sat_f = 32'sd2147483647;
    else if (v < -33'sd2147483647) sat_f = -32'sd2147483647;
    else                           sat_f = v[31:0];
  endfunction

  function automatic logic signed [23:0] step_pos(input logic signed [23:0] p,
                                                  input logic signed [31:0] f,
                                                  input logic [22:0] q);
    logic signed [25:0] s;
    s = f[31] ? 26'(p) - $signed({3'b0, q}) : 26'(p) + $signed({3'b0, q});
    if (s > 26'sd8388607)       step_pos = 24'sh7FFFFF;
    else if (s < -26'sd8388608) step_pos = 24'sh800000;
    else                        step_pos = s[23:0];
  endfunction

  assign dx  = 25'(gx_r) - 25'(pos_x_r);
  assign dy  = 25'(gy_r) - 25'(pos_y_r);
  assign px  = 25'(pos_x_r) - 25'(ox_r);
  assign py  = 25'(pos_y_r) - 25'(oy_r);
  assign adx = dx[24] ? 25'(-dx) : 25'(dx);
  assign ady = dy[24] ? 25'(-dy) : 25'(dy);
  assign apx = px[24] ? 25'(-px) : 25'(px);
  assign apy = py[24] ? 25'(-py) : 25'(py);
  assign afx = fx_r[31] ? 31'(-fx_r) : 31'(fx_r);
  assign afy = fy_r[31] ? 31'(-fy_r) : 31'(fy_r);

  // surface distance, clamped to one LSB
  assign surf_raw = $signed({1'b0, sq_res}) - $signed({12'b0, radius_r});
  assign surf_cl  = (surf_raw <= 34'sd0) ? 34'sd1 : surf_raw;

  always_comb begin
    mul_go  = 1'b0;
    sq_go   = 1'b0;
    dv_go   = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = SH_0;
    mul_cap = CAP_NONE;
    dv_num  = 55'(64'd1 << 36);
    dv_den  = 32'(surf_r);
    unique case (cmd.uop)
      U_DX2: begin mul_go = 1'b1; mul_a = 63'(adx); mul_b = 37'(adx); end
      U_DY2: begin mul_go = 1'b1; mul_a = 63'(ady); mul_b = 37'(ady); end
      U_PX2: begin mul_go = 1'b1; mul_a = 63'(apx); mul_b = 37'(apx); end
      U_PY2: begin mul_go = 1'b1; mul_a = 63'(apy); mul_b = 37'(apy); end
      U_FX2: begin mul_go = 1'b1; mul_a = 63'(afx); mul_b = 37'(afx); end
      U_FY2: begin mul_go = 1'b1; mul_a = 63'(afy); mul_b = 37'(afy); end
      U_FAX: begin
        mul_go = 1'b1; mul_a = 63'(adx); mul_b = 37'(attract_r);
        mul_sh = SH_8; mul_cap = CAP_F;
      end
      U_FAY: begin
        mul_go = 1'b1; mul_a = 63'(ady); mul_b = 37'(attract_r);
        mul_sh = SH_8; mul_cap = CAP_F;
      end
      U_G1, U_G2, U_G3: begin
        mul_go = 1'b1; mul_a = g_r; mul_b = invd_r;
        mul_sh = SH_24; mul_cap = CAP_G;
      end
      U_G4: begin
        mul_go = 1'b1; mul_a = g_r; mul_b = 37'(repel_r);
        mul_sh = SH_8; mul_cap = CAP_G;
      end
      U_RFX: begin
        mul_go = 1'b1; mul_a = g_r; mul_b = 37'(apx);
        mul_sh = SH_24; mul_cap = CAP_F;
      end
      U_RFY: begin
        mul_go = 1'b1; mul_a = g_r; mul_b = 37'(apy);
        mul_sh = SH_24; mul_cap = CAP_F;
      end
      U_SX: begin mul_go = 1'b1; mul_a = 63'(afx); mul_b = 37'(step_r); end
      U_SY: begin mul_go = 1'b1; mul_a = 63'(afy); mul_b = 37'(step_r); end
      U_SQG, U_SQO, U_SQF: sq_go = 1'b1;
      U_INVD: dv_go = 1'b1;
      U_INVD0: begin dv_go = 1'b1; dv_den = 32'(influence_r); end
      U_DVX: begin dv_go = 1'b1; dv_num = t0_r[54:0]; dv_den = fabs_r; end
      U_DVY: begin dv_go = 1'b1; dv_num = t1_r[54:0]; dv_den = fabs_r; end
      default: ;
    endcase
  end

  pfp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && mul_go), .a(mul_a), .b(mul_b),
    .sh(mul_sh), .cap(mul_cap), .done(mul_done), .res(mul_res)
  );

  pfp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && sq_go), .x(t0_r + t1_r),
    .done(sq_done), .res(sq_res)
  );

  pfp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && dv_go), .num(dv_num),
    .den(dv_den), .done(dv_done), .quo(dv_q)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attract_r   <= ATTRACT_RST;
      repel_r     <= REPEL_RST;
      influence_r <= INFLUENCE_RST;
      step_r      <= STEP_RST;
      arrive_r    <= ARRIVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTRACT:   attract_r   <= cfg_data[15:0];
        CFG_REPEL:     repel_r     <= cfg_data[15:0];
        CFG_INFLUENCE: influence_r <= cfg_data;
        CFG_STEP:      step_r      <= cfg_data;
        CFG_ARRIVE:    arrive_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // planner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      started_r <= 1'b0;
    end else if (cmd.load) begin
      if (in_data.start_valid && !started_r) begin
        pos_x_r   <= in_data.start_x;
        pos_y_r   <= in_data.start_y;
        started_r <= 1'b1;
      end
    end else if (cmd.wr && cmd.uop == U_DVX) begin
      pos_x_r <= step_pos(pos_x_r, fx_r, dv_q[22:0]);
    end else if (cmd.wr && cmd.uop == U_DVY) begin
      pos_y_r <= step_pos(pos_y_r, fy_r, dv_q[22:0]);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrived_r <= 1'b0;
      rep_r     <= 1'b0;
      pv_r      <= 1'b0;
    end else if (cmd.load) begin
      gx_r      <= in_data.goal_x;
      gy_r      <= in_data.goal_y;
      ox_r      <= in_data.obst_x;
      oy_r      <= in_data.obst_y;
      radius_r  <= in_data.obst_size[22:1];
      pt_x_r    <= '0;
      pt_y_r    <= '0;
      pv_r      <= 1'b0;
      rep_r     <= 1'b0;
      arrived_r <= 1'b0;
    end else if (cmd.wr) begin
      case (cmd.uop)
        U_DX2, U_PX2, U_FX2, U_SX: t0_r <= mul_res;
        U_DY2, U_PY2, U_FY2, U_SY: t1_r <= mul_res;
        U_SQG: begin
          arrived_r <= sq_res <= 32'(arrive_r);
          if (sq_res > 32'(arrive_r)) begin
            pv_r   <= 1'b1;
            pt_x_r <= pos_x_r;
            pt_y_r <= pos_y_r;
          end
        end
        U_FAX: fx_r <= dx[24] ? -$signed(mul_res[31:0]) : $signed(mul_res[31:0]);
        U_FAY: fy_r <= dy[24] ? -$signed(mul_res[31:0]) : $signed(mul_res[31:0]);
        U_SQO: begin
          surf_r <= surf_cl[22:0];
          rep_r  <= surf_cl < $signed({11'b0, influence_r});
        end
        U_INVD:  invd_r <= dv_q[36:0];
        U_INVD0: g_r <= 63'(invd_r - dv_q[36:0]);
        U_G1, U_G2, U_G3, U_G4: g_r <= mul_res[62:0];
        U_RFX: fx_r <= sat_f(33'(fx_r) + (px[24] ? -$signed({1'b0, mul_res[31:0]})
                                                 : $signed({1'b0, mul_res[31:0]})));
        U_RFY: fy_r <= sat_f(33'(fy_r) + (py[24] ? -$signed({1'b0, mul_res[31:0]})
                                                 : $signed({1'b0, mul_res[31:0]})));
        U_SQF: fabs_r <= sq_res;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.point_valid      <= pv_r;
      out_r.point_x          <= pt_x_r;
      out_r.point_y          <= pt_y_r;
      out_r.repulsion_active <= rep_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.started  = started_r;
  assign sts.arrived  = arrived_r;
  assign sts.rep      = rep_r;
  assign sts.fzero    = fabs_r == 32'd0;
  assign sts.done     = mul_done || sq_done || dv_done;
  assign sts.out_full = out_valid_r;

endmodule

/* design/pfp_ctrl.sv */
// Planner controller: walks the operation sequence of one tick and
// hands the result to the output register. Uses pfp_pkg.
`timescale 1ns / 1ps

module pfp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  pfp_pkg::sts_t sts,
  output pfp_pkg::cmd_t cmd
);
  import pfp_pkg::*;

  state_t state_r, state_nxt;
  uop_t   uop_r, uop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uop_r   <= U_DX2;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.wr    = 1'b0;
    cmd.emit  = 1'b0;
    cmd.uop   = uop_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          uop_nxt   = U_DX2;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (uop_r == U_DX2 && !sts.started) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.done) begin
          cmd.wr    = 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_nxt = ST_ISSUE;
        case (uop_r)
          U_SQG: if (sts.arrived) state_nxt = ST_FIN; else uop_nxt = U_FAX;
          U_SQO: uop_nxt = sts.rep ? U_INVD : U_FX2;
          U_RFY: uop_nxt = U_FX2;
          U_SQF: if (sts.fzero) state_nxt = ST_FIN; else uop_nxt = U_SX;
          U_DVY: state_nxt = ST_FIN;
          default: uop_nxt = uop_t'(uop_r + 5'd1);
        endcase
      end
      ST_FIN: begin
        if (!sts.out_full || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* tb/potential_field_planner_step_unit_tb.sv */
// Testbench for the potential-field planner step unit.
// Predicts each tick in plain SystemVerilog, checks results in order; needs pfp_pkg.
`timescale 1ns / 1ps

module potential_field_planner_step_unit_tb;
  import pfp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_ATTRACT;
  logic [22:0] cfg_data = '0;

  potential_field_planner_step_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and state
  logic [15:0] k_att, k_rep;
  logic [22:0] k_infl, k_step, k_arr;
  longint p_x, p_y;
  bit p_started;

  // expected results, written at acceptance and read in order
  out_item_t exp_mem [0:1023];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int n_points = 0;
  int n_rep = 0;
  int n_items = 0;
  int hold_cycles = 0;

  localparam longint FORCE_MAX = 64'sd2147483647;
  localparam longint POS_MAX = 64'sd8388607;
  localparam longint POS_MIN = -64'sd8388608;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                int s, longint unsigned cap);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> s;
    if (prod > {64'd0, cap}) return cap;
    return prod[63:0];
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scaled(longint v, longint unsigned g, int s);
    longint r;
    r = longint'(mul_shift(abs_of(v), g, s, FORCE_MAX));
    return v < 0 ? -r : r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic out_item_t plan_tick(in_item_t t);
    out_item_t r;
    longint dx, dy, px, py, fx, fy, surf, sx, sy;
    longint unsigned dg, dob, fmag, inv_d, inv_d0, g;
    r = '0;
    if (t.start_valid && !p_started) begin
      p_x = longint'(t.start_x);
      p_y = longint'(t.start_y);
      p_started = 1;
    end
    if (!p_started) return r;
    dx = longint'(t.goal_x) - p_x;
    dy = longint'(t.goal_y) - p_y;
    dg = int_sqrt(dx * dx + dy * dy);
    if (dg <= k_arr) return r;
    r.point_valid = 1'b1;
    r.point_x = p_x[23:0];
    r.point_y = p_y[23:0];
    fx = scaled(dx, k_att, 8);
    fy = scaled(dy, k_att, 8);
    px = p_x - longint'(t.obst_x);
    py = p_y - longint'(t.obst_y);
    dob = int_sqrt(px * px + py * py);
    surf = longint'(dob) - longint'(t.obst_size >> 1);
    if (surf <= 0) surf = 1;
    if (surf < longint'(k_infl)) begin
      inv_d = (64'd1 << 36) / surf;
      inv_d0 = (64'd1 << 36) / k_infl;
      g = inv_d - inv_d0;
      g = mul_shift(g, inv_d, 24, GCAP);
      g = mul_shift(g, inv_d, 24, GCAP);
      g = mul_shift(g, inv_d, 24, GCAP);
      g = mul_shift(g, k_rep, 8, GCAP);
      fx = clamp(fx + scaled(px, g, 24), -FORCE_MAX, FORCE_MAX);
      fy = clamp(fy + scaled(py, g, 24), -FORCE_MAX, FORCE_MAX);
      r.repulsion_active = 1'b1;
    end
    fmag = int_sqrt(abs_of(fx) * abs_of(fx) + abs_of(fy) * abs_of(fy));
    if (fmag != 0) begin
      sx = longint'((k_step * abs_of(fx)) / fmag);
      sy = longint'((k_step * abs_of(fy)) / fmag);
      p_x = clamp(p_x + (fx < 0 ? -sx : sx), POS_MIN, POS_MAX);
      p_y = clamp(p_y + (fy < 0 ? -sy : sy), POS_MIN, POS_MAX);
    end
    return r;
  endfunction

  // valid stays up after acceptance when the next request follows with no gap
  task automatic send_tick(in_item_t t);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_mem[exp_wr % 1024] = plan_tick(t);
    exp_wr++;
    n_items++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ATTRACT:   k_att = val[15:0];
      CFG_REPEL:     k_rep = val[15:0];
      CFG_INFLUENCE: k_infl = val;
      CFG_STEP:      k_step = val;
      CFG_ARRIVE:    k_arr = val;
      default: ;
    endcase
  endtask

  // drain, then let an ignored trailing tick finish before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // reset only clears the pose via reset, so restart by fresh reset is not allowed;
  // each phase instead reuses the latched pose
  function automatic in_item_t rand_tick(bit wide, logic [23:0] gx, logic [23:0] gy);
    in_item_t t;
    t.start_valid = 1'($urandom_range(0, 1));
    t.start_x = 24'($urandom);
    t.start_y = 24'($urandom);
    t.goal_x = wide ? 24'($urandom) : gx + 24'($urandom_range(0, 8191)) - 24'd4096;
    t.goal_y = wide ? 24'($urandom) : gy + 24'($urandom_range(0, 8191)) - 24'd4096;
    t.obst_x = p_x[23:0] + 24'($urandom_range(0, 8191)) - 24'd4096;
    t.obst_y = p_y[23:0] + 24'($urandom_range(0, 8191)) - 24'd4096;
    t.obst_size = ($urandom_range(0, 7) == 0) ? 23'($urandom) : 23'($urandom_range(0, 8191));
    if ($urandom_range(0, 9) == 0) begin
      t.obst_x = 24'($urandom);
      t.obst_y = 24'($urandom);
    end
    return t;
  endfunction

  task automatic test_directed();
    in_item_t t;
    t = '0;
    t.goal_x = 24'sd40960;
    t.goal_y = 24'sd20480;
    t.obst_x = 24'sd4000;
    send_tick(t);             // not started
    t.start_valid = 1'b1;
    t.start_x = 24'sd100;
    t.start_y = -24'sd200;
    send_tick(t);             // latch start
    t.start_x = 24'h7fffff;
    send_tick(t);             // start while started is ignored
    t.start_valid = 1'b0;
    t.obst_x = 24'sd100;
    t.obst_y = -24'sd200;
    t.obst_size = 23'h7fffff; // inside the obstacle
    send_tick(t);
    t.obst_size = 23'd0;      // centre on the robot
    send_tick(t);
    t.obst_x = 24'sd300;
    t.obst_size = 23'd300;
    send_tick(t);
    t.goal_x = p_x[23:0];
    t.goal_y = p_y[23:0];     // arrived
    send_tick(t);
    t.goal_x = 24'h800000;
    t.goal_y = 24'h7fffff;
    t.obst_x = 24'h7fffff;
    t.obst_y = 24'h800000;
    t.obst_size = 23'd1;
    send_tick(t);
    t.goal_x = 24'h7fffff;
    t.goal_y = 24'h800000;
    t.obst_x = 24'h800000;
    t.obst_y = 24'h7fffff;
    send_tick(t);
    wait_idle();
    write_reg(CFG_ATTRACT, 23'd0);   // zero force case
    write_reg(CFG_INFLUENCE, 23'd1);
    t.obst_x = 24'h7fffff;
    t.obst_y = 24'h7fffff;
    send_tick(t);
    wait_idle();
    write_reg(CFG_ATTRACT, 23'hffff);
    write_reg(CFG_REPEL, 23'hffff);
    write_reg(CFG_STEP, 23'h7fffff);
    write_reg(CFG_INFLUENCE, 23'h7fffff);
    write_reg(CFG_ARRIVE, 23'd0);
    repeat (4) send_tick(rand_tick(1'b1, 24'd0, 24'd0));
    wait_idle();
  endtask

  task automatic test_random_phase(int count, logic [15:0] att, logic [15:0] rep,
                                   logic [22:0] infl, logic [22:0] stp, logic [22:0] arr);
    int i;
    write_reg(CFG_ATTRACT, 23'(att));
    write_reg(CFG_REPEL, 23'(rep));
    write_reg(CFG_INFLUENCE, infl);
    write_reg(CFG_STEP, stp);
    write_reg(CFG_ARRIVE, arr);
    for (i = 0; i < count; i++)
      send_tick(rand_tick($urandom_range(0, 3) == 0, p_x[23:0] + 24'sd40960, p_y[23:0]));
    wait_idle();
  endtask

  task automatic test_backpressure();
    int i;
    hold_cycles = 3000;
    for (i = 0; i < 8; i++) send_tick(rand_tick(1'b0, p_x[23:0] - 24'sd30000, p_y[23:0]));
    wait_idle();
  endtask

  // result side: a random wait per result, plus one long hold-off on request
  initial begin
    int w;
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        @(posedge clk);
        hold_cycles--;
      end else begin
        w = $urandom_range(0, 3);
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_rd == exp_wr) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = exp_mem[exp_rd % 1024];
        exp_rd++;
        if (want.repulsion_active) n_rep++;
        if (want.point_valid) n_points++;
        if (out_data.point_valid !== want.point_valid || out_data.point_x !== want.point_x ||
            out_data.point_y !== want.point_y ||
            out_data.repulsion_active !== want.repulsion_active) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected v=%0d x=%0d y=%0d r=%0d got v=%0d x=%0d y=%0d r=%0d",
                     want.point_valid, want.point_x, want.point_y, want.repulsion_active,
                     out_data.point_valid, out_data.point_x, out_data.point_y,
                     out_data.repulsion_active);
        end
      end
    end
  end

  initial begin
    k_att = ATTRACT_RST;
    k_rep = REPEL_RST;
    k_infl = INFLUENCE_RST;
    k_step = STEP_RST;
    k_arr = ARRIVE_RST;
    p_x = 0;
    p_y = 0;
    p_started = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(150, ATTRACT_RST, REPEL_RST, INFLUENCE_RST, STEP_RST, ARRIVE_RST);
    test_random_phase(150, 16'd1, 16'd0, 23'd8192, 23'd4096, 23'd0);
    test_backpressure();
    test_random_phase(150, 16'hffff, 16'hffff, 23'h7fffff, 23'd0, 23'd2000);
    test_random_phase(150, 16'd512, 16'd40, 23'd6000, 23'd800, 23'h7fffff);
    test_random_phase(40, 16'd300, 16'd9000, 23'd3000, 23'd2500, 23'd100);
    $display("%0d ticks sent, %0d path points, %0d with repulsion active", n_items, n_points,
             n_rep);
    $display("register extremes, start latching, arrival and a long output stall covered");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
